// File: rtl/slist_pkg.sv
// Shared types, codes and sizes for the sorted list engine.
package slist_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_SORT  = 3'd0,
    CMD_INS_FRONT = 3'd1,
    CMD_REMOVE    = 3'd2,
    CMD_SEARCH    = 3'd3,
    CMD_MODIFY    = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    cmd_e op;
    logic en;
  } ctrl_t;

  // Handed from each cell to the next toward the tail.
  typedef struct packed {
    logic             all_lt;
    logic             hit;
    logic [POS_W-1:0] pos;
  } chain_t;

endpackage

// File: rtl/slist_req_if.sv
// Request channel: command and operands.
interface slist_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [slist_pkg::CMD_W-1:0]          cmd;
  logic signed [slist_pkg::DATA_W-1:0]  value;
  logic signed [slist_pkg::DATA_W-1:0]  new_value;

  modport source (output valid, cmd, value, new_value, input ready);
  modport sink   (input valid, cmd, value, new_value, output ready);
endinterface

// File: rtl/slist_rsp_if.sv
// Response channel: status, removed head value and search position.
interface slist_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [slist_pkg::STATUS_W-1:0]       status;
  logic signed [slist_pkg::DATA_W-1:0]  removed_value;
  logic [slist_pkg::POS_W-1:0]          position;

  modport source (output valid, status, removed_value, position, input ready);
  modport sink   (input valid, status, removed_value, position, output ready);
endinterface

// File: rtl/slist_cell.sv
// One list slot: holds an entry, compares it and shifts with its neighbors.
module slist_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned CW  = 5
) (
  input  logic                                clk_i,
  input  slist_pkg::ctrl_t                    ctrl_i,
  input  logic [CW-1:0]                       count_i,
  input  logic signed [slist_pkg::DATA_W-1:0] value_i,
  input  logic signed [slist_pkg::DATA_W-1:0] new_value_i,
  input  logic signed [slist_pkg::DATA_W-1:0] left_i,
  input  logic signed [slist_pkg::DATA_W-1:0] right_i,
  input  slist_pkg::chain_t                   chain_i,
  output slist_pkg::chain_t                   chain_o,
  output logic signed [slist_pkg::DATA_W-1:0] entry_o
);

  logic signed [slist_pkg::DATA_W-1:0] entry_q, entry_d;
  logic occ, lt_self, eq_self;

  assign occ     = CW'(IDX) < count_i;
  assign lt_self = occ && (entry_q < value_i);
  assign eq_self = occ && (entry_q == value_i);

  assign chain_o.all_lt = chain_i.all_lt && lt_self;
  assign chain_o.hit    = chain_i.hit || eq_self;
  assign chain_o.pos    = chain_i.hit ? chain_i.pos :
                          (eq_self ? slist_pkg::POS_W'(IDX + 1) : '0);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.en) begin
      case (ctrl_i.op)
        slist_pkg::CMD_INS_SORT: begin
          if (!chain_i.all_lt) begin
            entry_d = left_i;
          end else if (!lt_self) begin
            entry_d = value_i;
          end
        end
        slist_pkg::CMD_INS_FRONT: entry_d = left_i;
        slist_pkg::CMD_REMOVE:    entry_d = right_i;
        slist_pkg::CMD_MODIFY: begin
          if (eq_self && !chain_i.hit) begin
            entry_d = new_value_i;
          end
        end
        default: entry_d = entry_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: rtl/sorted_list_engine.sv
// Top level of the sorted list engine: cell chain, fill count and response register.
//
// Bounded ordered list of signed 32-bit values held in a row of CAPACITY cells,
// head in cell 0. Each request on req_i carries a command (sorted insert, front
// insert, remove head, search, modify) and yields one response on rsp_o with a
// status, the removed head value and the 1-based search position.
//
// Every cell compares its entry with the request value at once; the first-match
// and insertion-point flags ripple from cell to cell, and all cells shift or
// load together in the accepting cycle. The response is registered and appears in
// the cycle after acceptance, and one request can be taken every cycle while rsp_o
// is not stalled.
//
// The response sits in an output register. While a response waits, req_i is
// taken only if that response leaves in the same cycle.
//
// Reset (rst_ni low) empties the list and drops any pending response; entry
// contents are not cleared and never read while unoccupied.
module sorted_list_engine #(
  parameter int unsigned CAPACITY = slist_pkg::CAPACITY
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  slist_req_if.sink    req_i,
  slist_rsp_if.source  rsp_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count_q, count_d;
  logic          full, empty, accept;
  logic          rsp_valid_q;
  logic [slist_pkg::STATUS_W-1:0]       status_q, status_d;
  logic signed [slist_pkg::DATA_W-1:0]  removed_q, removed_d;
  logic [slist_pkg::POS_W-1:0]          pos_q, pos_d;

  slist_pkg::ctrl_t  ctrl;
  slist_pkg::cmd_e   op;
  slist_pkg::chain_t chain [CAPACITY+1];
  logic signed [slist_pkg::DATA_W-1:0] entry [CAPACITY];
  logic          hit;

  assign full   = count_q == CW'(CAPACITY);
  assign empty  = count_q == '0;
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept = req_i.valid && req_i.ready;
  assign op     = slist_pkg::cmd_e'(req_i.cmd);

  assign chain[0].all_lt = 1'b1;
  assign chain[0].hit    = 1'b0;
  assign chain[0].pos    = '0;
  assign hit = chain[CAPACITY].hit;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic signed [slist_pkg::DATA_W-1:0] left, right;
    if (k == 0) begin : g_head
      assign left = req_i.value;
    end else begin : g_left
      assign left = entry[k-1];
    end
    if (k == CAPACITY - 1) begin : g_tail
      assign right = entry[k];
    end else begin : g_right
      assign right = entry[k+1];
    end
    slist_cell #(
      .IDX(k),
      .CW (CW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .count_i    (count_q),
      .value_i    (req_i.value),
      .new_value_i(req_i.new_value),
      .left_i     (left),
      .right_i    (right),
      .chain_i    (chain[k]),
      .chain_o    (chain[k+1]),
      .entry_o    (entry[k])
    );
  end

  // command decode and result
  always_comb begin
    ctrl.op   = op;
    ctrl.en   = 1'b0;
    count_d   = count_q;
    status_d  = slist_pkg::ST_OK;
    removed_d = '0;
    pos_d     = '0;
    case (op)
      slist_pkg::CMD_INS_SORT, slist_pkg::CMD_INS_FRONT: begin
        if (full) begin
          status_d = slist_pkg::ST_FULL;
        end else begin
          ctrl.en = accept;
          count_d = count_q + CW'(1);
        end
      end
      slist_pkg::CMD_REMOVE: begin
        if (empty) begin
          status_d = slist_pkg::ST_EMPTY;
        end else begin
          ctrl.en   = accept;
          count_d   = count_q - CW'(1);
          removed_d = entry[0];
        end
      end
      slist_pkg::CMD_SEARCH: begin
        if (empty) begin
          status_d = slist_pkg::ST_EMPTY;
        end else if (!hit) begin
          status_d = slist_pkg::ST_NOT_FOUND;
        end else begin
          pos_d = chain[CAPACITY].pos;
        end
      end
      slist_pkg::CMD_MODIFY: begin
        if (!hit) begin
          status_d = slist_pkg::ST_NOT_FOUND;
        end else begin
          ctrl.en = accept;
        end
      end
      default: ctrl.en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
      pos_q     <= pos_d;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.removed_value = removed_q;
  assign rsp_o.position      = pos_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && (op == slist_pkg::CMD_INS_SORT || op == slist_pkg::CMD_INS_FRONT)
    |=> rsp_valid_q && status_q == slist_pkg::ST_FULL && $stable(count_q))
    else $error("insert into full list not rejected");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.en && op == slist_pkg::CMD_REMOVE |=> count_q == $past(count_q) - CW'(1))
    else $error("remove did not shrink the list");

  a_search_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op == slist_pkg::CMD_SEARCH
    |=> (status_q == slist_pkg::ST_OK) == (pos_q != '0))
    else $error("search position and status disagree");

endmodule
